// ===== rtl/core/ljcpfa_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and saturating helpers for the lennard-jones pair force accumulator
// no dependencies

package ljcpfa_pkg;

    localparam int NUM_TYPES = 2;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] H_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd24;
    localparam logic [63:0] S48_MAX_MAG = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] S48_MIN_MAG = 64'h0000_8000_0000_0000;
    localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

    typedef enum logic [2:0] {
        CFG_CUTOFF_SQ = 3'd0,
        CFG_SIGMA_AA  = 3'd1,
        CFG_SIGMA_AB  = 3'd2,
        CFG_SIGMA_BB  = 3'd3,
        CFG_EPS_AA    = 3'd4,
        CFG_EPS_AB    = 3'd5,
        CFG_EPS_BB    = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_SQX, PH_SQY, PH_SQZ, PH_CUT, PH_SG2, PH_U2, PH_U4, PH_U6, PH_U12,
        PH_DIFF, PH_EM, PH_HM, PH_ET, PH_PX, PH_FX, PH_PY, PH_FY, PH_PZ, PH_FZ,
        PH_ACC, PH_EMIT
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   go;
        logic   wb;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic in_range;
        logic last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic        sat;
        logic [47:0] val;
    } s48_res_t;

    function automatic s48_res_t to_s48(input logic neg, input logic [63:0] mag);
        s48_res_t r;
        if (neg) begin
            r.sat = (mag > S48_MIN_MAG);
            r.val = r.sat ? S48_MIN : (48'd0 - mag[47:0]);
        end else begin
            r.sat = (mag > S48_MAX_MAG);
            r.val = r.sat ? S48_MAX : mag[47:0];
        end
        return r;
    endfunction

    function automatic s48_res_t acc_add(input logic [47:0] a, input logic [47:0] b);
        s48_res_t    r;
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        r.sat = (s[48] != s[47]);
        r.val = r.sat ? (s[48] ? S48_MIN : S48_MAX) : s[47:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/ljcpfa_mul.sv =====
`timescale 1ns / 1ps
// 64x64 unsigned multiplier, one 32x32 partial product per cycle, 128-bit product
// depends on nothing

module ljcpfa_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         pp_vld_reg;
    logic         done_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;

    assign a_part = cnt_reg[1] ? a[63:32] : a[31:0];
    assign b_part = cnt_reg[0] ? b[63:32] : b[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= 3'd0;
                pp_vld_reg <= 1'b0;
            end else if (busy_reg) begin
                if (!cnt_reg[2]) begin
                    pp_vld_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + 3'd1;
                end else begin
                    pp_vld_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + ({64'd0, pp_reg} << {pp_sh_reg, 5'd0});
            end
            if (!cnt_reg[2]) begin
                pp_reg    <= a_part * b_part;
                pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/ljcpfa_div.sv =====
`timescale 1ns / 1ps
// bit-serial restoring divider: floor(a * 2^sh / b) saturated to 64 bits, sh is 32 or 48
// depends on nothing

module ljcpfa_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic        sh48,
    input  logic [63:0] b,
    output logic [63:0] quot,
    output logic        sat,
    output logic        done
);

    localparam logic [63:0] ALL_ONES_C = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         busy_reg;
    logic [6:0]   cnt_reg;
    logic         done_reg;
    logic [127:0] num_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         over_reg;
    logic [63:0]  rem_sh;
    logic         take;

    assign rem_sh = {rem_reg[62:0], num_reg[127]};
    assign take   = rem_reg[63] || (rem_sh >= b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 7'd127;
                if (a == 64'd0 || b == 64'd0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= sh48 ? {16'd0, a, 48'd0} : {32'd0, a, 32'd0};
            rem_reg  <= 64'd0;
            q_reg    <= 64'd0;
            over_reg <= (a != 64'd0) && (b == 64'd0);
        end else if (busy_reg) begin
            num_reg  <= {num_reg[126:0], 1'b0};
            rem_reg  <= take ? (rem_sh - b) : rem_sh;
            over_reg <= over_reg | q_reg[63];
            q_reg    <= {q_reg[62:0], take};
        end
    end

    assign quot = over_reg ? ALL_ONES_C : q_reg;
    assign sat  = over_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/ljcpfa_datapath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, item capture, shared multiplier and divider, sums, result register
// depends on ljcpfa_pkg, ljcpfa_mul, ljcpfa_div

module ljcpfa_datapath
    import ljcpfa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    input  cmd_t         cmd,
    output status_t      status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata
);

    logic [31:0] cutoff_sq_reg;
    logic [23:0] sigma_aa_reg, sigma_ab_reg, sigma_bb_reg;
    logic [31:0] eps_aa_reg, eps_ab_reg, eps_bb_reg;

    logic [15:0] atom_reg;
    logic        ts_reg, tn_reg, last_reg;
    logic [31:0] dmag_reg [0:2];
    logic        dneg_reg [0:2];
    logic [63:0] r2_reg, sg2_reg, u2_reg, u4_reg, u6_reg, u12_reg;
    logic [63:0] wmag_reg, gmag_reg, emag_reg, h_reg, p_reg;
    logic        wneg_reg, gneg_reg;
    logic [47:0] et_reg, ftx_reg, fty_reg, ftz_reg;
    logic [47:0] eacc_reg, fxacc_reg, fyacc_reg, fzacc_reg;
    logic        sticky_reg;
    logic        m_tvalid_reg;
    logic [215:0] m_tdata_reg;

    logic [23:0]  sg;
    logic [31:0]  ep;
    logic         mul_start, div_start, div_sh48, div_sat, mul_done, div_done;
    logic [63:0]  mul_a, mul_b, div_a, div_q;
    logic [127:0] mul_prod;
    logic [63:0]  mq;
    logic         mq_sat;
    logic         sat_now;
    logic         accept, emit;
    logic [31:0]  in_v [0:2];
    logic [64:0]  u12x2_full;
    logic [63:0]  u12x2;
    logic         wneg_c, gneg_c;
    logic         h_big;
    s48_res_t     ft_res, et_res, ae, ax, ay, az;
    logic         dneg_sel;

    // type pair selection
    always_comb begin
        logic tsel, nsel;
        tsel = (NUM_TYPES > 1) ? ts_reg : 1'b0;
        nsel = (NUM_TYPES > 1) ? tn_reg : 1'b0;
        if (tsel != nsel) begin
            sg = sigma_ab_reg;
            ep = eps_ab_reg;
        end else if (tsel) begin
            sg = sigma_bb_reg;
            ep = eps_bb_reg;
        end else begin
            sg = sigma_aa_reg;
            ep = eps_aa_reg;
        end
    end

    // operand select
    always_comb begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        div_a = {32'd0, dmag_reg[0]};
        div_sh48 = 1'b1;
        dneg_sel = dneg_reg[0];
        case (cmd.phase)
            PH_SQX:  begin mul_a = {32'd0, dmag_reg[0]}; mul_b = {32'd0, dmag_reg[0]}; end
            PH_SQY:  begin mul_a = {32'd0, dmag_reg[1]}; mul_b = {32'd0, dmag_reg[1]}; end
            PH_SQZ:  begin mul_a = {32'd0, dmag_reg[2]}; mul_b = {32'd0, dmag_reg[2]}; end
            PH_SG2:  begin mul_a = {40'd0, sg}; mul_b = {40'd0, sg}; end
            PH_U4:   begin mul_a = u2_reg; mul_b = u2_reg; end
            PH_U6:   begin mul_a = u4_reg; mul_b = u2_reg; end
            PH_U12:  begin mul_a = u6_reg; mul_b = u6_reg; end
            PH_EM:   begin mul_a = wmag_reg; mul_b = {32'd0, ep}; end
            PH_HM:   begin mul_a = gmag_reg; mul_b = {32'd0, ep}; end
            PH_FX:   begin mul_a = h_reg; mul_b = p_reg; dneg_sel = dneg_reg[0]; end
            PH_FY:   begin mul_a = h_reg; mul_b = p_reg; dneg_sel = dneg_reg[1]; end
            PH_FZ:   begin mul_a = h_reg; mul_b = p_reg; dneg_sel = dneg_reg[2]; end
            PH_U2:   begin div_a = sg2_reg; div_sh48 = 1'b0; end
            PH_PY:   div_a = {32'd0, dmag_reg[1]};
            PH_PZ:   div_a = {32'd0, dmag_reg[2]};
            default: ;
        endcase
    end

    assign mul_start = cmd.go && !(cmd.phase inside {PH_U2, PH_PX, PH_PY, PH_PZ});
    assign div_start = cmd.go && (cmd.phase inside {PH_U2, PH_PX, PH_PY, PH_PZ});

    ljcpfa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    ljcpfa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (div_a),
        .sh48    (div_sh48),
        .b       (r2_reg),
        .quot    (div_q),
        .sat     (div_sat),
        .done    (div_done)
    );

    assign mq_sat = |mul_prod[127:96];
    assign mq     = mq_sat ? ALL_ONES : mul_prod[95:32];

    assign u12x2_full = {1'b0, u12_reg} + {1'b0, u12_reg};
    assign u12x2      = u12x2_full[64] ? ALL_ONES : u12x2_full[63:0];
    assign wneg_c     = u12_reg < u6_reg;
    assign gneg_c     = u12x2 < u6_reg;
    assign h_big      = mq > H_LIMIT;
    assign et_res     = to_s48(wneg_reg && (emag_reg != 64'd0), emag_reg);
    assign ft_res     = to_s48((gneg_reg != dneg_sel) && (mq != 64'd0), mq);
    assign ae         = acc_add(eacc_reg, et_reg);
    assign ax         = acc_add(fxacc_reg, ftx_reg);
    assign ay         = acc_add(fyacc_reg, fty_reg);
    assign az         = acc_add(fzacc_reg, ftz_reg);

    always_comb begin
        sat_now = 1'b0;
        case (cmd.phase)
            PH_U2, PH_PX, PH_PY, PH_PZ: sat_now = div_sat;
            PH_U4, PH_U6, PH_U12:       sat_now = mq_sat;
            PH_DIFF:                    sat_now = u12x2_full[64];
            PH_EM:                      sat_now = mq_sat | (mq[63:62] != 2'b00);
            PH_HM:                      sat_now = mq_sat | h_big;
            PH_ET:                      sat_now = et_res.sat;
            PH_FX, PH_FY, PH_FZ:        sat_now = mq_sat | ft_res.sat;
            PH_ACC:                     sat_now = ae.sat | ax.sat | ay.sat | az.sat;
            default:                    sat_now = 1'b0;
        endcase
    end

    assign accept = cmd.wb && (cmd.phase == PH_IDLE) && s_tvalid;
    assign emit   = cmd.wb && (cmd.phase == PH_EMIT);

    assign in_v[0] = s_tdata[47:16];
    assign in_v[1] = s_tdata[79:48];
    assign in_v[2] = s_tdata[111:80];

    // config registers and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_sq_reg <= 32'd0;
            sigma_aa_reg  <= 24'd0;
            sigma_ab_reg  <= 24'd0;
            sigma_bb_reg  <= 24'd0;
            eps_aa_reg    <= 32'd0;
            eps_ab_reg    <= 32'd0;
            eps_bb_reg    <= 32'd0;
            eacc_reg      <= 48'd0;
            fxacc_reg     <= 48'd0;
            fyacc_reg     <= 48'd0;
            fzacc_reg     <= 48'd0;
            sticky_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CUTOFF_SQ: cutoff_sq_reg <= cfg_data;
                    CFG_SIGMA_AA:  sigma_aa_reg  <= cfg_data[23:0];
                    CFG_SIGMA_AB:  sigma_ab_reg  <= cfg_data[23:0];
                    CFG_SIGMA_BB:  sigma_bb_reg  <= cfg_data[23:0];
                    CFG_EPS_AA:    eps_aa_reg    <= cfg_data;
                    CFG_EPS_AB:    eps_ab_reg    <= cfg_data;
                    CFG_EPS_BB:    eps_bb_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.wb && sat_now) begin
                sticky_reg <= 1'b1;
            end
            if (cmd.wb && cmd.phase == PH_ACC) begin
                eacc_reg  <= ae.val;
                fxacc_reg <= ax.val;
                fyacc_reg <= ay.val;
                fzacc_reg <= az.val;
            end
            if (emit) begin
                eacc_reg     <= 48'd0;
                fxacc_reg    <= 48'd0;
                fyacc_reg    <= 48'd0;
                fzacc_reg    <= 48'd0;
                sticky_reg   <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            atom_reg <= s_tdata[15:0];
            ts_reg   <= s_tuser[0];
            tn_reg   <= s_tuser[1];
            last_reg <= s_tlast;
            for (int k = 0; k < 3; k++) begin
                dneg_reg[k] <= in_v[k][31];
                dmag_reg[k] <= in_v[k][31] ? (32'd0 - in_v[k]) : in_v[k];
            end
        end
        if (cmd.wb) begin
            case (cmd.phase)
                PH_SQX:  r2_reg  <= mul_prod[63:0];
                PH_SQY, PH_SQZ: r2_reg <= r2_reg + mul_prod[63:0];
                PH_SG2:  sg2_reg <= mul_prod[63:0];
                PH_U2:   u2_reg  <= div_q;
                PH_U4:   u4_reg  <= mq;
                PH_U6:   u6_reg  <= mq;
                PH_U12:  u12_reg <= mq;
                PH_DIFF: begin
                    wneg_reg <= wneg_c;
                    gneg_reg <= gneg_c;
                    wmag_reg <= wneg_c ? (u6_reg - u12_reg) : (u12_reg - u6_reg);
                    gmag_reg <= gneg_c ? (u6_reg - u12x2) : (u12x2 - u6_reg);
                end
                PH_EM:   emag_reg <= (mq[63:62] != 2'b00) ? ALL_ONES : {mq[61:0], 2'b00};
                PH_HM:   h_reg    <= h_big ? ALL_ONES : ((mq << 4) + (mq << 3));
                PH_ET:   et_reg   <= et_res.val;
                PH_PX, PH_PY, PH_PZ: p_reg <= div_q;
                PH_FX:   ftx_reg  <= ft_res.val;
                PH_FY:   fty_reg  <= ft_res.val;
                PH_FZ:   ftz_reg  <= ft_res.val;
                default: ;
            endcase
        end
        if (emit) begin
            m_tdata_reg <= {7'd0, sticky_reg, fzacc_reg, fyacc_reg, fxacc_reg, eacc_reg,
                            atom_reg};
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.in_range = r2_reg < {16'd0, cutoff_sq_reg, 16'd0};
    assign status.last     = last_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/ljcpfa_ctrl.sv =====
`timescale 1ns / 1ps
// controller: steps one pair through the datapath phases and starts the shared units
// depends on ljcpfa_pkg

module ljcpfa_ctrl
    import ljcpfa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    phase_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   unit_done;
    phase_t follow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= PH_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_comb begin
        case (state_reg)
            PH_SQX:  follow = PH_SQY;
            PH_SQY:  follow = PH_SQZ;
            PH_SQZ:  follow = PH_CUT;
            PH_SG2:  follow = PH_U2;
            PH_U2:   follow = PH_U4;
            PH_U4:   follow = PH_U6;
            PH_U6:   follow = PH_U12;
            PH_U12:  follow = PH_DIFF;
            PH_DIFF: follow = PH_EM;
            PH_EM:   follow = PH_HM;
            PH_HM:   follow = PH_ET;
            PH_ET:   follow = PH_PX;
            PH_PX:   follow = PH_FX;
            PH_FX:   follow = PH_PY;
            PH_PY:   follow = PH_FY;
            PH_FY:   follow = PH_PZ;
            PH_PZ:   follow = PH_FZ;
            PH_FZ:   follow = PH_ACC;
            default: follow = PH_IDLE;
        endcase
    end

    assign unit_done = (state_reg inside {PH_U2, PH_PX, PH_PY, PH_PZ}) ?
                       status.div_done : status.mul_done;

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        s_tready    = 1'b0;
        cmd.phase   = state_reg;
        cmd.go      = 1'b0;
        cmd.wb      = 1'b0;
        case (state_reg)
            PH_IDLE: begin
                s_tready = 1'b1;
                cmd.wb   = 1'b1;
                if (s_tvalid) begin
                    state_next = PH_SQX;
                end
            end
            PH_CUT: begin
                if (status.in_range) begin
                    state_next = PH_SG2;
                end else begin
                    state_next = status.last ? PH_EMIT : PH_IDLE;
                end
            end
            PH_DIFF, PH_ET: begin
                cmd.wb     = 1'b1;
                state_next = follow;
            end
            PH_ACC: begin
                cmd.wb     = 1'b1;
                state_next = status.last ? PH_EMIT : PH_IDLE;
            end
            PH_EMIT: begin
                if (status.out_free) begin
                    cmd.wb     = 1'b1;
                    state_next = PH_IDLE;
                end
            end
            default: begin
                if (!issued_reg) begin
                    cmd.go      = 1'b1;
                    issued_next = 1'b1;
                end else if (unit_done) begin
                    cmd.wb      = 1'b1;
                    issued_next = 1'b0;
                    state_next  = follow;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/lj_cut_pair_force_accumulator.sv =====
`timescale 1ns / 1ps
// top level of the truncated 12-6 lennard-jones pair force and energy accumulator
// depends on ljcpfa_pkg, ljcpfa_ctrl, ljcpfa_datapath

// One neighbor pair word is taken at a time. A pair at or beyond the cutoff goes through the
// accept and cutoff states and three squares on the shared multiplier; a pair inside the cutoff
// spends most of its time in the bit-serial divider, on its four divisions, and makes twelve
// passes in all through the 64x64 multiplier that forms one 32x32 partial product per cycle.
// On the word flagged last one more state moves the sums to an output register, so the next
// pair is taken while the result waits to be read; that state stalls only while an earlier
// result is still waiting.

module lj_cut_pair_force_accumulator
    import ljcpfa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // atom_index, disp_x, disp_y, disp_z
    input  logic [1:0]   s_tuser,  // type_self, type_neigh
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata   // atom_out, energy_sum, force_x, force_y, force_z, overflow
);

    cmd_t    cmd;
    status_t status;

    ljcpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ljcpfa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== verif/lj_cut_pair_force_accumulator_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lj_cut_pair_force_accumulator: directed table, then random neighbor runs
// depends on ljcpfa_pkg and the rtl of lj_cut_pair_force_accumulator

module lj_cut_pair_force_accumulator_test;

    typedef struct {
        logic [15:0] atom;
        logic [47:0] energy;
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] fz;
        logic        ovf;
    } atom_sums_t;

    typedef struct {
        int          setting;
        logic [15:0] atom;
        logic        ts;
        logic        tn;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic        last;
        bit          typed;
        atom_sums_t  sums;
    } pair_row_t;

    localparam int SETTLE_CYCLES = 800;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int HOLD_CYCLES = 20000;
    localparam int RANDOM_ITEMS = 1900;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // atom_index, disp_x, disp_y, disp_z
    logic [1:0]   s_tuser;   // type_self, type_neigh
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;   // atom_out, energy_sum, force_x, force_y, force_z, overflow

    lj_cut_pair_force_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [31:0]        cut_sq_r;
    logic [23:0]        sig_r [3];
    logic [31:0]        eps_r [3];
    logic signed [47:0] e_acc, fx_acc, fy_acc, fz_acc;
    logic               ovf_acc;
    bit                 sat_seen;

    atom_sums_t sums_expect_q [$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_token = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    longint     cycles = 0;

    function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:96] != 0) begin
            sat_seen = 1'b1;
            return ONES64;
        end
        return p[95:32];
    endfunction

    function automatic logic [63:0] frac_div(logic [63:0] a, int sh, logic [63:0] b);
        logic [127:0] n;
        logic [127:0] q;
        if (a == 0) return 64'd0;
        if (b == 0) begin
            sat_seen = 1'b1;
            return ONES64;
        end
        n = {64'd0, a} << sh;
        q = n / {64'd0, b};
        if (q[127:64] != 0) begin
            sat_seen = 1'b1;
            return ONES64;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] scale_by(logic [63:0] a, logic [63:0] k);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, k};
        if (p[127:64] != 0) begin
            sat_seen = 1'b1;
            return ONES64;
        end
        return p[63:0];
    endfunction

    function automatic logic [47:0] clamp48(logic neg, logic [63:0] mag);
        if (neg) begin
            if (mag > 64'h0000_8000_0000_0000) begin
                sat_seen = 1'b1;
                return 48'h8000_0000_0000;
            end
            return 48'd0 - mag[47:0];
        end
        if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
            sat_seen = 1'b1;
            return 48'h7FFF_FFFF_FFFF;
        end
        return mag[47:0];
    endfunction

    function automatic logic [47:0] sum48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) begin
            sat_seen = 1'b1;
            return s[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end
        return s[47:0];
    endfunction

    // accumulate one neighbor pair; returns 1 with the atom sums when the pair closes the atom
    function automatic bit lj_pair_update(pair_row_t r, output atom_sums_t res);
        logic [31:0] d [3];
        logic [63:0] dmag [3];
        logic        dneg [3];
        logic [63:0] r2, sg, ep, u2, u6, u12, u12x2, wmag, gmag, emag, h, p, fm;
        logic        wneg, gneg;
        logic [47:0] et;
        logic [47:0] ft [3];
        int          sel;
        d[0] = r.dx;
        d[1] = r.dy;
        d[2] = r.dz;
        r2 = 0;
        sat_seen = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dneg[k] = d[k][31];
            dmag[k] = {32'd0, dneg[k] ? (32'd0 - d[k]) : d[k]};
            r2 = r2 + dmag[k] * dmag[k];
        end
        if (r2 < {16'd0, cut_sq_r, 16'd0}) begin
            sel = (r.ts != r.tn) ? 1 : (r.ts ? 2 : 0);
            sg = {40'd0, sig_r[sel]};
            ep = {32'd0, eps_r[sel]};
            u2 = frac_div(sg * sg, 32, r2);
            u6 = frac_mul(frac_mul(u2, u2), u2);
            u12 = frac_mul(u6, u6);
            u12x2 = u12 + u12;
            if (u12x2 < u12) begin
                sat_seen = 1'b1;
                u12x2 = ONES64;
            end
            wneg = u12 < u6;
            gneg = u12x2 < u6;
            wmag = wneg ? u6 - u12 : u12 - u6;
            gmag = gneg ? u6 - u12x2 : u12x2 - u6;
            emag = scale_by(frac_mul(wmag, ep), 64'd4);
            h = scale_by(frac_mul(gmag, ep), 64'd24);
            et = clamp48(wneg && emag != 0, emag);
            for (int k = 0; k < 3; k++) begin
                p = frac_div(dmag[k], 48, r2);
                fm = frac_mul(h, p);
                ft[k] = clamp48((gneg != dneg[k]) && fm != 0, fm);
            end
            e_acc = sum48(e_acc, et);
            fx_acc = sum48(fx_acc, ft[0]);
            fy_acc = sum48(fy_acc, ft[1]);
            fz_acc = sum48(fz_acc, ft[2]);
            if (sat_seen) ovf_acc = 1'b1;
        end
        if (!r.last) return 1'b0;
        res.atom = r.atom;
        res.energy = e_acc;
        res.fx = fx_acc;
        res.fy = fy_acc;
        res.fz = fz_acc;
        res.ovf = ovf_acc;
        e_acc = 0;
        fx_acc = 0;
        fy_acc = 0;
        fz_acc = 0;
        ovf_acc = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_pair(pair_row_t r);
        atom_sums_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.dz, r.dy, r.dx, r.atom};
        s_tuser <= {r.tn, r.ts};
        s_tlast <= r.last;
        do @(posedge aclk); while (!s_tready);
        if (lj_pair_update(r, res)) sums_expect_q.push_back(r.typed ? r.sums : res);
    endtask

    // block must be idle before the registers change
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sums_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(logic [31:0] v [7]);
        ljcpfa_pkg::cfg_idx_t idx;
        drain();
        for (int i = 0; i < 7; i++) begin
            idx = ljcpfa_pkg::cfg_idx_t'(i);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= v[i];
            @(posedge aclk);
            case (idx)
                ljcpfa_pkg::CFG_CUTOFF_SQ: cut_sq_r = v[i];
                ljcpfa_pkg::CFG_SIGMA_AA:  sig_r[0] = v[i][23:0];
                ljcpfa_pkg::CFG_SIGMA_AB:  sig_r[1] = v[i][23:0];
                ljcpfa_pkg::CFG_SIGMA_BB:  sig_r[2] = v[i][23:0];
                ljcpfa_pkg::CFG_EPS_AA:    eps_r[0] = v[i];
                ljcpfa_pkg::CFG_EPS_AB:    eps_r[1] = v[i];
                default:                   eps_r[2] = v[i];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_disp(int kind);
        case (kind)
            0: return 32'($signed($urandom_range(0, 393216)) - 196608);
            1: return $urandom();
            2: return 32'($signed($urandom_range(0, 32768)) - 16384);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // receiver side with checking
    always @(posedge aclk) begin
        atom_sums_t want;
        logic [15:0] got_atom;
        logic [47:0] got_e, got_x, got_y, got_z;
        logic        got_ovf;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lj_cut_pair_force_accumulator regression: fail");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                got_atom = m_tdata[15:0];
                got_e = m_tdata[63:16];
                got_x = m_tdata[111:64];
                got_y = m_tdata[159:112];
                got_z = m_tdata[207:160];
                got_ovf = m_tdata[208];
                if (sums_expect_q.size() == 0) begin
                    $display("%0t unexpected word atom %h", $time, got_atom);
                    errors++;
                end else begin
                    want = sums_expect_q.pop_front();
                    if (got_atom !== want.atom) begin
                        $display("%0t atom exp %h got %h", $time, want.atom, got_atom);
                        errors++;
                    end
                    if (got_e !== want.energy) begin
                        $display("%0t energy exp %h got %h", $time, want.energy, got_e);
                        errors++;
                    end
                    if (got_x !== want.fx) begin
                        $display("%0t force_x exp %h got %h", $time, want.fx, got_x);
                        errors++;
                    end
                    if (got_y !== want.fy) begin
                        $display("%0t force_y exp %h got %h", $time, want.fy, got_y);
                        errors++;
                    end
                    if (got_z !== want.fz) begin
                        $display("%0t force_z exp %h got %h", $time, want.fz, got_z);
                        errors++;
                    end
                    if (got_ovf !== want.ovf) begin
                        $display("%0t overflow exp %b got %b", $time, want.ovf, got_ovf);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        pair_row_t   pair_table [$];
        pair_row_t   r;
        atom_sums_t  zero_sums;
        logic [31:0] presets [3][7];
        logic [31:0] v [7];
        int          cur;
        int          sent;
        int          run_len;
        int          kind;

        presets[0] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        presets[1] = '{32'h0006_4000, 32'h0001_0000, 32'h0001_4000, 32'h0000_8000,
                       32'h0001_0000, 32'h0000_8000, 32'h0002_0000};
        presets[2] = '{32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

        cut_sq_r = 0;
        for (int i = 0; i < 3; i++) begin
            sig_r[i] = 0;
            eps_r[i] = 0;
        end
        e_acc = 0;
        fx_acc = 0;
        fy_acc = 0;
        fz_acc = 0;
        ovf_acc = 1'b0;
        zero_sums = '{16'h0, 48'h0, 48'h0, 48'h0, 48'h0, 1'b0};

        // setting, atom, ts, tn, dx, dy, dz, last, typed, sums
        pair_table = '{
            '{0, 16'h0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, zero_sums},
            '{0, 16'hFFFF, 1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1,
              '{16'hFFFF, 48'h0, 48'h0, 48'h0, 48'h0, 1'b0}},
            '{0, 16'h1234, 0, 1, 32'h0, 32'h0, 32'h0, 1, 1,
              '{16'h1234, 48'h0, 48'h0, 48'h0, 48'h0, 1'b0}},
            '{1, 16'h0010, 0, 0, 32'h0001_2000, 32'h0, 32'h0, 0, 0, zero_sums},
            '{1, 16'h0011, 0, 1, 32'h0, 32'h0001_8000, 32'h0, 0, 0, zero_sums},
            '{1, 16'h0012, 1, 0, 32'h0, 32'hFFFE_8000, 32'h0000_4000, 0, 0, zero_sums},
            '{1, 16'h0013, 1, 1, 32'h0, 32'h0, 32'hFFFF_0000, 1, 0, zero_sums},
            '{1, 16'h0020, 0, 0, 32'h0, 32'h0, 32'h0, 1, 0, zero_sums},
            '{1, 16'h0030, 0, 0, 32'h0002_8000, 32'h0, 32'h0, 1, 1,
              '{16'h0030, 48'h0, 48'h0, 48'h0, 48'h0, 1'b0}},
            '{1, 16'h0031, 1, 1, 32'h0002_7FFF, 32'h0, 32'h0, 1, 0, zero_sums},
            '{1, 16'h0040, 0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1,
              '{16'h0040, 48'h0, 48'h0, 48'h0, 48'h0, 1'b0}},
            '{2, 16'h0050, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, zero_sums},
            '{2, 16'h0051, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, zero_sums},
            '{2, 16'h0060, 0, 1, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1, 0, zero_sums},
            '{2, 16'h0070, 1, 1, 32'h0, 32'h0, 32'h0, 1, 0, zero_sums}
        };

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= ljcpfa_pkg::CFG_CUTOFF_SQ;
        cfg_data <= 32'h0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        s_tlast <= 1'b0;
        m_tready <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur = 0;
        foreach (pair_table[i]) begin
            if (pair_table[i].setting != cur) begin
                cur = pair_table[i].setting;
                program_regs(presets[cur]);
            end
            send_pair(pair_table[i]);
        end

        sent = 0;
        for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
            case (ph % 6)
                1: v = presets[2];
                2: v = '{32'hFFFF_FFFF, 32'h0, 32'h00FF_FFFF, 32'h0001_0000,
                         32'h0, 32'h0001_0000, 32'h0};
                3: v = '{32'h0000_0100, 32'h0000_1000, 32'h0000_2000, 32'h0000_0800,
                         $urandom(), $urandom(), $urandom()};
                default: begin
                    v[0] = $urandom_range(32'h0000_4000, 32'h000A_0000);
                    for (int i = 1; i < 4; i++) v[i] = $urandom_range(32'h8000, 32'h1_8000);
                    for (int i = 4; i < 7; i++) v[i] = $urandom_range(0, 32'h0004_0000);
                end
            endcase
            program_regs(v);
            // long receiver stall while the sender keeps going
            if (ph == 0) hold_token++;
            for (int n = 0; n < 320 && sent < RANDOM_ITEMS; ) begin
                if (sent < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 11;
                    rx_idle_pct = 52;
                end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 52;
                    rx_idle_pct = 11;
                end else begin
                    send_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                run_len = $urandom_range(1, 8);
                r.setting = 0;
                r.atom = $urandom();
                r.ts = $urandom_range(1);
                r.typed = 0;
                r.sums = zero_sums;
                for (int j = 0; j < run_len; j++) begin
                    kind = $urandom_range(99);
                    kind = (kind < 70) ? 0 : (kind < 85) ? 1 : (kind < 95) ? 2 : 3;
                    r.tn = $urandom_range(1);
                    r.dx = rand_disp(kind);
                    r.dy = rand_disp(kind);
                    r.dz = rand_disp(kind);
                    r.last = (j == run_len - 1) || ($urandom_range(49) == 0);
                    if (j != 0 && $urandom_range(3) == 0) r.atom = $urandom();
                    send_pair(r);
                    n++;
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("lj_cut_pair_force_accumulator regression: pass");
        end else begin
            $display("lj_cut_pair_force_accumulator regression: fail");
        end
        $finish;
    end

endmodule
